FILE: src/afk_pkg.sv
// ----------------------------------------------------------------------------
// afk_pkg
// Shared types, constants and helper functions of the arm kinematics block.
// ----------------------------------------------------------------------------
`default_nettype none

package afk_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int CFG_COUNT = 6;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_TOOL_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOOL_Z    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREARM_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FOREARM_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_H    = 3'd5;

    localparam logic signed [15:0] RST_TOOL_X    = 16'sd4915;
    localparam logic signed [15:0] RST_TOOL_Z    = 16'sd1311;
    localparam logic signed [15:0] RST_FOREARM_X = 16'sd6554;
    localparam logic signed [15:0] RST_FOREARM_Y = 16'sd1311;
    localparam logic signed [15:0] RST_UPPER_X   = 16'sd6554;
    localparam logic signed [15:0] RST_BASE_H    = 16'sd8192;

    // Gain-compensated starting x of the CORDIC, Q2.30.
    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef struct packed {
        logic signed [15:0] tool_x;
        logic signed [15:0] tool_z;
        logic signed [15:0] forearm_x;
        logic signed [15:0] forearm_y;
        logic signed [15:0] upper_x;
        logic signed [15:0] base_h;
    } t_cfg;

    // One rotation in flight: vector, residual angle and quadrant.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [31:0] z;
        logic [1:0]         q;
    } t_cord;

    // Base, shoulder and elbow travel side by side.
    typedef t_cord [2:0] t_cord3;

    function automatic logic signed [31:0] atan_of(input logic [4:0] idx);
        logic signed [31:0] v;
        case (idx)
            5'd0:  v = 32'sd536870912;
            5'd1:  v = 32'sd316933406;
            5'd2:  v = 32'sd167458907;
            5'd3:  v = 32'sd85004756;
            5'd4:  v = 32'sd42667331;
            5'd5:  v = 32'sd21354465;
            5'd6:  v = 32'sd10680350;
            5'd7:  v = 32'sd5340245;
            5'd8:  v = 32'sd2670163;
            5'd9:  v = 32'sd1335087;
            5'd10: v = 32'sd667544;
            5'd11: v = 32'sd333772;
            5'd12: v = 32'sd166886;
            5'd13: v = 32'sd83443;
            5'd14: v = 32'sd41722;
            5'd15: v = 32'sd20861;
            5'd16: v = 32'sd10430;
            5'd17: v = 32'sd5215;
            5'd18: v = 32'sd2608;
            5'd19: v = 32'sd1304;
            5'd20: v = 32'sd652;
            5'd21: v = 32'sd326;
            5'd22: v = 32'sd163;
            5'd23: v = 32'sd81;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [19:0] sat20(input logic signed [29:0] v);
        logic signed [19:0] r;
        if (v > 30'sd524287) begin
            r = 20'sd524287;
        end else if (v < -30'sd524288) begin
            r = -20'sd524288;
        end else begin
            r = v[19:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/afk_cell.sv
// ----------------------------------------------------------------------------
// afk_cell
// One CORDIC micro-rotation for the three joint angles, with its own
// valid/ready register so that cells form an elastic chain.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_cell
    import afk_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic [4:0] i_idx,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_cord3 i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_cord3      o_data
);

    logic   r_valid;
    t_cord3 r_data;
    t_cord3 n_data;
    logic signed [31:0] w_atan;

    assign w_atan  = atan_of(i_idx);
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_data[j].q = i_data[j].q;
            if (!i_data[j].z[31]) begin
                n_data[j].x = i_data[j].x - (i_data[j].y >>> i_idx);
                n_data[j].y = i_data[j].y + (i_data[j].x >>> i_idx);
                n_data[j].z = i_data[j].z - w_atan;
            end else begin
                n_data[j].x = i_data[j].x + (i_data[j].y >>> i_idx);
                n_data[j].y = i_data[j].y - (i_data[j].x >>> i_idx);
                n_data[j].z = i_data[j].z + w_atan;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/afk_kin.sv
// ----------------------------------------------------------------------------
// afk_kin
// Quadrant fix-up of the sine and cosine, then the elbow, shoulder and base
// rotations, each as a product stage followed by a sum and round stage.
// ----------------------------------------------------------------------------
`default_nettype none

module afk_kin
    import afk_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_cfg   i_cfg,
    input  wire logic   i_valid,
    output logic        o_ready,
    input  wire t_cord3 i_data,
    output logic        o_valid,
    input  wire logic   i_ready,
    output logic signed [19:0] o_pos_x,
    output logic signed [19:0] o_pos_y,
    output logic signed [19:0] o_pos_z
);

    logic [6:0] r_v;
    logic [6:0] w_rdy;

    // Stage 0: cos/sin, Q2.15; index 0 base, 1 shoulder, 2 elbow.
    logic signed [17:0] r_c [3];
    logic signed [17:0] r_s [3];
    logic signed [17:0] n_c [3];
    logic signed [17:0] n_s [3];
    // Stage 1: elbow products.
    logic signed [33:0] r_e_cx, r_e_sz, r_e_cz, r_e_sx;
    logic signed [17:0] r1_cs, r1_ss, r1_cb, r1_sb;
    // Stage 2.
    logic signed [20:0] r_px;
    logic signed [19:0] r_pz;
    logic signed [17:0] r2_cs, r2_ss, r2_cb, r2_sb;
    // Stage 3: shoulder products.
    logic signed [38:0] r_s_cx, r_s_sz, r_s_cz, r_s_sx;
    logic signed [17:0] r3_cb, r3_sb;
    // Stage 4.
    logic signed [25:0] r_qx;
    logic signed [24:0] r_qz;
    logic signed [17:0] r4_cb, r4_sb;
    // Stage 5: base products.
    logic signed [43:0] r_b_cx, r_b_sy, r_b_sx, r_b_cy;
    logic signed [25:0] r_rz;
    // Stage 6: output register.
    logic signed [19:0] r_ox, r_oy, r_oz;

    logic signed [34:0] w_cc, w_ss;
    logic signed [34:0] w_e1, w_e2;
    logic signed [39:0] w_s1, w_s2;
    logic signed [44:0] w_b1, w_b2;

    always_comb begin
        w_rdy[6] = !r_v[6] || i_ready;
        for (int k = 5; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[6];
    assign o_pos_x = r_ox;
    assign o_pos_y = r_oy;
    assign o_pos_z = r_oz;

    // Undo the quadrant reduction and round to Q2.15.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            case (i_data[j].q)
                2'd0: begin
                    w_cc = 35'(i_data[j].x);
                    w_ss = 35'(i_data[j].y);
                end
                2'd1: begin
                    w_cc = -35'(i_data[j].y);
                    w_ss = 35'(i_data[j].x);
                end
                2'd2: begin
                    w_cc = -35'(i_data[j].x);
                    w_ss = -35'(i_data[j].y);
                end
                default: begin
                    w_cc = 35'(i_data[j].y);
                    w_ss = -35'(i_data[j].x);
                end
            endcase
            w_cc   = w_cc + 35'sd16384;
            w_ss   = w_ss + 35'sd16384;
            n_c[j] = w_cc[32:15];
            n_s[j] = w_ss[32:15];
        end
    end

    assign w_e1 = 35'(r_e_cx) + 35'(r_e_sz) + 35'sd16384;
    assign w_e2 = 35'(r_e_cz) - 35'(r_e_sx) + 35'sd16384;
    assign w_s1 = 40'(r_s_cx) + 40'(r_s_sz) + 40'sd16384;
    assign w_s2 = 40'(r_s_cz) - 40'(r_s_sx) + 40'sd16384;
    assign w_b1 = 45'(r_b_cx) - 45'(r_b_sy) + 45'sd16384;
    assign w_b2 = 45'(r_b_sx) + 45'(r_b_cy) + 45'sd16384;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k < 7; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0] && i_valid) begin
            r_c <= n_c;
            r_s <= n_s;
        end
        if (w_rdy[1] && r_v[0]) begin
            r_e_cx <= 34'(r_c[2]) * 34'(i_cfg.tool_x);
            r_e_sz <= 34'(r_s[2]) * 34'(i_cfg.tool_z);
            r_e_cz <= 34'(r_c[2]) * 34'(i_cfg.tool_z);
            r_e_sx <= 34'(r_s[2]) * 34'(i_cfg.tool_x);
            r1_cs  <= r_c[1];
            r1_ss  <= r_s[1];
            r1_cb  <= r_c[0];
            r1_sb  <= r_s[0];
        end
        if (w_rdy[2] && r_v[1]) begin
            r_px  <= 21'($signed(w_e1[34:15])) + 21'(i_cfg.forearm_x);
            r_pz  <= w_e2[34:15];
            r2_cs <= r1_cs;
            r2_ss <= r1_ss;
            r2_cb <= r1_cb;
            r2_sb <= r1_sb;
        end
        if (w_rdy[3] && r_v[2]) begin
            r_s_cx <= 39'(r2_cs) * 39'(r_px);
            r_s_sz <= 39'(r2_ss) * 39'(r_pz);
            r_s_cz <= 39'(r2_cs) * 39'(r_pz);
            r_s_sx <= 39'(r2_ss) * 39'(r_px);
            r3_cb  <= r2_cb;
            r3_sb  <= r2_sb;
        end
        if (w_rdy[4] && r_v[3]) begin
            r_qx  <= 26'($signed(w_s1[39:15])) + 26'(i_cfg.upper_x);
            r_qz  <= w_s2[39:15];
            r4_cb <= r3_cb;
            r4_sb <= r3_sb;
        end
        if (w_rdy[5] && r_v[4]) begin
            // The y coordinate before the base rotation is the forearm y offset.
            r_b_cx <= 44'(r4_cb) * 44'(r_qx);
            r_b_sy <= 44'(r4_sb) * 44'(i_cfg.forearm_y);
            r_b_sx <= 44'(r4_sb) * 44'(r_qx);
            r_b_cy <= 44'(r4_cb) * 44'(i_cfg.forearm_y);
            r_rz   <= 26'(r_qz) + 26'(i_cfg.base_h);
        end
        if (w_rdy[6] && r_v[5]) begin
            r_ox <= sat20(w_b1[44:15]);
            r_oy <= sat20(w_b2[44:15]);
            r_oz <= sat20(30'(r_rz));
        end
    end

endmodule

`default_nettype wire

FILE: src/arm_forward_kinematics.sv
// ----------------------------------------------------------------------------
// arm_forward_kinematics
// Tool-tip position of a four-joint serial arm from its joint angles.
// ----------------------------------------------------------------------------
// The block takes one pose item per cycle unless the output side stalls.
// The Q4.15 tool position reaches the output register through 23 register
// stages: one for each of the 16 CORDIC cells, which work on the base,
// shoulder and elbow angles side by side, and seven for the quadrant
// fix-up, the three rotations (a product and a sum stage each) and the
// output register. Every stage has its own valid bit, so a stalled result
// only holds the stages behind it once they fill. The wrist angle is taken
// but does not move the tip. The user must write link offsets through the
// configuration port only while no item is in flight; the block itself
// does not enforce this.
`default_nettype none

module arm_forward_kinematics
    import afk_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [15:0] i_base_angle,
    input  wire logic [15:0] i_shoulder_angle,
    input  wire logic [15:0] i_elbow_angle,
    input  wire logic [15:0] i_wrist_angle,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic signed [19:0] o_pos_x,
    output logic signed [19:0] o_pos_y,
    output logic signed [19:0] o_pos_z
);

    t_cfg   r_cfg;
    t_cord3 w_d   [CORDIC_STAGES+1];
    logic   w_v   [CORDIC_STAGES+1];
    logic   w_rdy [CORDIC_STAGES+1];
    logic [15:0] w_ang [3];
    logic [31:0] w_phase [3];
    logic [1:0]  w_q [3];
    logic        w_wrist_unused;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tool_x    <= RST_TOOL_X;
            r_cfg.tool_z    <= RST_TOOL_Z;
            r_cfg.forearm_x <= RST_FOREARM_X;
            r_cfg.forearm_y <= RST_FOREARM_Y;
            r_cfg.upper_x   <= RST_UPPER_X;
            r_cfg.base_h    <= RST_BASE_H;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_TOOL_X:    r_cfg.tool_x    <= i_cfg_data;
                CFG_TOOL_Z:    r_cfg.tool_z    <= i_cfg_data;
                CFG_FOREARM_X: r_cfg.forearm_x <= i_cfg_data;
                CFG_FOREARM_Y: r_cfg.forearm_y <= i_cfg_data;
                CFG_UPPER_X:   r_cfg.upper_x   <= i_cfg_data;
                CFG_BASE_H:    r_cfg.base_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_ang[0] = i_base_angle;
    assign w_ang[1] = i_shoulder_angle;
    assign w_ang[2] = i_elbow_angle;
    assign w_wrist_unused = ^i_wrist_angle;

    // Scale to a 32-bit phase and strip the nearest quadrant, leaving a
    // residual within an eighth of a turn for the CORDIC.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            w_phase[j] = 32'(w_ang[j]) << (32 - ANGLE_BITS);
            w_q[j]     = 2'((w_phase[j] + 32'h2000_0000) >> 30);
            w_d[0][j].q = w_q[j];
            w_d[0][j].z = w_phase[j] - {w_q[j], 30'd0};
            w_d[0][j].x = CORDIC_X0;
            w_d[0][j].y = '0;
        end
    end

    assign w_v[0]  = i_valid;
    assign o_ready = w_rdy[0];

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
        afk_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_idx   (5'(g)),
            .i_valid (w_v[g]),
            .o_ready (w_rdy[g]),
            .i_data  (w_d[g]),
            .o_valid (w_v[g+1]),
            .i_ready (w_rdy[g+1]),
            .o_data  (w_d[g+1])
        );
    end

    afk_kin u_kin (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_v[CORDIC_STAGES]),
        .o_ready (w_rdy[CORDIC_STAGES]),
        .i_data  (w_d[CORDIC_STAGES]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_pos_x (o_pos_x),
        .o_pos_y (o_pos_y),
        .o_pos_z (o_pos_z)
    );

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the arm forward kinematics block.
// ----------------------------------------------------------------------------
// Pose items are queued by the stimulus process and driven by a clocked
// driver. The expected tool position of each item is computed when the item
// is accepted. A clocked monitor checks every result against the oldest
// expected position. Link offsets are changed between phases, and the idling
// on both sides changes from phase to phase.
`timescale 1ns / 100ps
`default_nettype none

module tb_top
    import afk_pkg::*;
();

    localparam int  FLUSH_CYCLES = 40;
    localparam int  CYCLE_LIMIT  = 600000;
    localparam int  PHASES       = 8;
    localparam int  PHASE_ITEMS  = 140;

    typedef struct {
        logic [15:0] base;
        logic [15:0] shoulder;
        logic [15:0] elbow;
        logic [15:0] wrist;
    } t_pose;

    typedef struct {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
    } t_tip;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_base_angle;
    logic [15:0] i_shoulder_angle;
    logic [15:0] i_elbow_angle;
    logic [15:0] i_wrist_angle;
    logic        o_valid;
    logic        i_ready;
    logic signed [19:0] o_pos_x;
    logic signed [19:0] o_pos_y;
    logic signed [19:0] o_pos_z;

    arm_forward_kinematics dut (.*);

    t_pose pose_queue[$];
    t_tip  tip_queue[$];
    logic signed [15:0] link[CFG_COUNT];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    fail_count;
    int    result_count;
    int    cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic longint round_q15(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic void sin_cos(input logic [15:0] ang, output longint c,
                                    output longint s);
        logic [31:0] phase;
        logic [31:0] resid;
        logic [1:0]  quad;
        longint      x;
        longint      y;
        longint      z;
        longint      nx;
        phase = {ang, 16'h0000};
        quad  = 2'((phase + 32'h2000_0000) >> 30);
        resid = phase - {quad, 30'b0};
        z = longint'($signed(resid));
        x = 652032874;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_of(5'(i)));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_of(5'(i)));
            end
            x = nx;
        end
        case (quad)
            2'd0: begin c = x;  s = y;  end
            2'd1: begin c = -y; s = x;  end
            2'd2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
        c = round_q15(c);
        s = round_q15(s);
    endfunction

    function automatic logic signed [19:0] clamp20(input longint v);
        if (v > 524287) return 20'sd524287;
        if (v < -524288) return -20'sd524288;
        return 20'(v);
    endfunction

    function automatic t_tip tool_tip(input t_pose p);
        longint cb, sb, cs, ss, ce, se;
        longint tx, tz, fx, fy, ux;
        longint px, pz, qx, qz;
        t_tip   r;
        sin_cos(p.base, cb, sb);
        sin_cos(p.shoulder, cs, ss);
        sin_cos(p.elbow, ce, se);
        tx = link[CFG_TOOL_X];
        tz = link[CFG_TOOL_Z];
        fx = link[CFG_FOREARM_X];
        fy = link[CFG_FOREARM_Y];
        ux = link[CFG_UPPER_X];
        px = round_q15(ce * tx + se * tz) + fx;
        pz = round_q15(ce * tz - se * tx);
        qx = round_q15(cs * px + ss * pz) + ux;
        qz = round_q15(cs * pz - ss * px);
        r.x = clamp20(round_q15(cb * qx - sb * fy));
        r.y = clamp20(round_q15(sb * qx + cb * fy));
        r.z = clamp20(qz + longint'(link[CFG_BASE_H]));
        return r;
    endfunction

    // Driver: predicts on acceptance, then offers the next item unless idling.
    always @(posedge i_clk) begin
        t_pose p;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                p.base = i_base_angle;
                p.shoulder = i_shoulder_angle;
                p.elbow = i_elbow_angle;
                p.wrist = i_wrist_angle;
                tip_queue.push_back(tool_tip(p));
            end
            if (!i_valid || o_ready) begin
                if (pose_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    p = pose_queue.pop_front();
                    i_valid          <= 1'b1;
                    i_base_angle     <= p.base;
                    i_shoulder_angle <= p.shoulder;
                    i_elbow_angle    <= p.elbow;
                    i_wrist_angle    <= p.wrist;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_tip e;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
            if (o_valid && i_ready) begin
                result_count++;
                if (tip_queue.size() == 0) begin
                    $error("result with no item outstanding");
                    fail_count++;
                end else begin
                    e = tip_queue.pop_front();
                    if (o_pos_x !== e.x) begin
                        $error("pos_x: expected %0d, got %0d", e.x, o_pos_x);
                        fail_count++;
                    end
                    if (o_pos_y !== e.y) begin
                        $error("pos_y: expected %0d, got %0d", e.y, o_pos_y);
                        fail_count++;
                    end
                    if (o_pos_z !== e.z) begin
                        $error("pos_z: expected %0d, got %0d", e.z, o_pos_z);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", tip_queue.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_link(input logic [2:0] idx, input logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx < CFG_COUNT) link[idx] = data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pose_queue.size() > 0 || tip_queue.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [15:0] random_angle();
        logic [15:0] a;
        a = 16'($urandom);
        // Now and then land close to a quadrant boundary.
        if ($urandom_range(3) == 0)
            a = {a[15:14], 14'h2000} + 16'($signed(5'($urandom)));
        return a;
    endfunction

    function automatic logic [15:0] link_value(input int mode);
        case (mode)
            1: return 16'h7FFF;
            2: return 16'h8000;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] corner[8];
        t_pose p;
        corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000,
                   16'hC000, 16'h2000, 16'h1FFF, 16'h6000};
        link[CFG_TOOL_X]    = RST_TOOL_X;
        link[CFG_TOOL_Z]    = RST_TOOL_Z;
        link[CFG_FOREARM_X] = RST_FOREARM_X;
        link[CFG_FOREARM_Y] = RST_FOREARM_Y;
        link[CFG_UPPER_X]   = RST_UPPER_X;
        link[CFG_BASE_H]    = RST_BASE_H;
        fail_count = 0;
        result_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_base_angle = '0;
        i_shoulder_angle = '0;
        i_elbow_angle = '0;
        i_wrist_angle = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed poses at the reset link lengths.
        foreach (corner[k]) begin
            p.base = corner[k];
            p.shoulder = corner[(k + 3) % 8];
            p.elbow = corner[(k + 5) % 8];
            p.wrist = corner[(k + 1) % 8];
            pose_queue.push_back(p);
            p.base = corner[(k + 6) % 8];
            p.shoulder = corner[k];
            p.elbow = corner[k];
            p.wrist = ~corner[k];
            pose_queue.push_back(p);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                for (int r = 0; r < CFG_COUNT; r++)
                    write_link(3'(r), link_value(ph % 5));
                // Indexes past the last register must be ignored.
                write_link(3'(CFG_COUNT), 16'($urandom));
                write_link(3'(CFG_COUNT + 1), 16'($urandom));
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                p.base = random_angle();
                p.shoulder = random_angle();
                p.elbow = random_angle();
                p.wrist = 16'($urandom);
                pose_queue.push_back(p);
            end
            drain();
        end

        $display("Checked %0d tool positions over %0d link settings,", result_count,
                 PHASES);
        $display("with corner angles, quadrant edges and varied handshake idling.");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
